// ===== design/nca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nca_pkg: shared types and constants of the nearest centroid assignment
// Field widths, stream packing, register map, controller states and the
// control group broadcast from the controller to the distance cells.
// ----------------------------------------------------------------------------
package nca_pkg;

  // Default sizing of the centroid table
  localparam int MAX_CLUSTERS_DEF   = 8;
  localparam int MAX_DIMENSIONS_DEF = 16;

  // Field widths
  localparam int DATA_W = 16;
  localparam int DIST_W = 36;
  localparam int CIDX_W = 3;
  localparam int FIDX_W = 4;
  localparam int ACT_W  = 4;
  localparam int SQ_W   = 32;

  // Stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Saturation value of a running distance
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Word kinds carried on in_tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  // Register map: word index taken from paddr above the byte lanes
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_ACTIVE_CLUSTERS = 1'b0;
  localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

  // Controller states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_SWEEP,
    ST_HOLD
  } nca_state_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic wr_en;   // load word in range; each cell matches its own index itself
    logic rd_en;   // point feature in range: read centroid coordinate
    logic acc_en;  // squared difference in stage two is to be added
  } nca_ctrl_t;

endpackage
`default_nettype wire

// ===== design/nca_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nca_cell: one centroid of the chain
// Holds one centroid row and its running squared distance. On a compare
// token from the left it keeps the better candidate, passes it right and
// clears its running distance.
// ----------------------------------------------------------------------------
module nca_cell #(
  parameter int CELL_IDX       = 0,
  parameter int MAX_DIMENSIONS = nca_pkg::MAX_DIMENSIONS_DEF,
  parameter int DIW            = 4,
  parameter int IDX_W          = 3
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  nca_pkg::nca_ctrl_t           ctrl,
  input  wire                          active,
  input  wire [nca_pkg::CIDX_W-1:0]    ld_cidx,
  input  wire [DIW-1:0]                addr,
  input  wire [nca_pkg::DATA_W-1:0]    wr_data,
  input  wire [nca_pkg::DATA_W-1:0]    feat,
  input  wire                          tok_in_vld,
  input  wire [IDX_W-1:0]              tok_in_idx,
  input  wire [nca_pkg::DIST_W-1:0]    tok_in_dist,
  output logic                         tok_out_vld,
  output logic [IDX_W-1:0]             tok_out_idx,
  output logic [nca_pkg::DIST_W-1:0]   tok_out_dist
);

  logic [nca_pkg::DATA_W-1:0] row_mem [MAX_DIMENSIONS];
  logic [nca_pkg::DATA_W-1:0] cent_r;
  logic [nca_pkg::SQ_W-1:0]   sq_r;
  logic [nca_pkg::DIST_W-1:0] acc_r;
  logic [nca_pkg::DIST_W-1:0] acc_nxt;
  logic                       tok_vld_r;
  logic [IDX_W-1:0]           tok_idx_r;
  logic [nca_pkg::DIST_W-1:0] tok_dist_r;
  logic                       wr_sel;
  logic signed [nca_pkg::DATA_W:0] diff;
  logic [nca_pkg::DATA_W:0]   mag_full;
  logic [nca_pkg::DATA_W-1:0] mag;
  logic [nca_pkg::DIST_W:0]   sum;
  logic                       take_own;

  assign wr_sel = ctrl.wr_en && (32'(ld_cidx) == CELL_IDX);

  // Write a loaded coordinate, read the one a feature needs
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      row_mem[addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      cent_r <= row_mem[addr];
    end
  end

  // Difference is exact in 17 bits, its magnitude fits 16
  always_comb begin
    diff     = $signed({feat[nca_pkg::DATA_W-1], feat})
             - $signed({cent_r[nca_pkg::DATA_W-1], cent_r});
    mag_full = diff[nca_pkg::DATA_W] ? 17'(-diff) : 17'(diff);
    mag      = mag_full[nca_pkg::DATA_W-1:0];
  end

  // Square stage
  always_ff @(posedge clk) begin
    sq_r <= mag * mag;
  end

  // Saturating add, and the compare against the token from the left
  always_comb begin
    sum      = {1'b0, acc_r} + {5'b0, sq_r};
    acc_nxt  = sum[nca_pkg::DIST_W] ? nca_pkg::DIST_MAX : sum[nca_pkg::DIST_W-1:0];
    take_own = active && (acc_r < tok_in_dist);
  end

  // Accumulate, then clear once the token has seen this cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (tok_in_vld) begin
      acc_r <= '0;
    end else if (ctrl.acc_en && active) begin
      acc_r <= acc_nxt;
    end
  end

  // Hand the best candidate so far to the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_vld) begin
      tok_idx_r  <= take_own ? IDX_W'(CELL_IDX) : tok_in_idx;
      tok_dist_r <= take_own ? acc_r : tok_in_dist;
    end
  end

  assign tok_out_vld  = tok_vld_r;
  assign tok_out_idx  = tok_idx_r;
  assign tok_out_dist = tok_dist_r;

endmodule
`default_nettype wire

// ===== design/nearest_centroid_assign.sv =====
// Path: a point's last feature passes three distance stages, then the compare
//   chain at one cell a cycle, then two hops (result and output registers).
// Throughput: loads and non-final features one word per cycle; a final
//   feature holds in_tready low during the compare chain sweep, and
//   longer while the previous result still waits on out_tready.
// Reset: synchronous, active low; clears running distances, control and
//   active_clusters (to 8). The centroid table is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_centroid_assign: k-means nearest centroid assignment
// Loads a centroid table, accumulates squared distances of streamed point
// features in a chain of cells, and returns the nearest centroid per point.
// ----------------------------------------------------------------------------
module nearest_centroid_assign #(
  parameter int MAX_CLUSTERS   = nca_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_DIMENSIONS = nca_pkg::MAX_DIMENSIONS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // tdata: cluster_index[2:0], feature_index[6:3], feature_value[22:7], zero pad
  input  wire [nca_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: action (0 load coordinate, 1 point feature)
  input  wire                               in_tuser,
  input  wire                               in_tlast,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // tdata: nearest_cluster[2:0], min_distance[38:3], zero pad
  output logic [nca_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire [nca_pkg::CFG_AW-1:0]         cfg_paddr,
  input  wire [nca_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [nca_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int DIW   = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int IDX_W = $clog2(MAX_CLUSTERS);

  nca_pkg::nca_state_t state_r, state_nxt;
  nca_pkg::nca_ctrl_t  ctrl;

  logic [nca_pkg::ACT_W-1:0]  act_r;
  logic [nca_pkg::CIDX_W-1:0] in_cidx;
  logic [nca_pkg::FIDX_W-1:0] in_fidx;
  logic [nca_pkg::DATA_W-1:0] in_value;
  logic                       in_fire;
  logic                       cidx_ok;
  logic                       fidx_ok;
  logic                       is_point;
  logic                       last_point;
  logic                       out_load;
  logic [DIW-1:0]             addr;

  logic [nca_pkg::DATA_W-1:0] feat_a_r;
  logic                       a_vld_r, b_vld_r;
  logic                       a_last_r, b_last_r, c_last_r;
  logic [MAX_CLUSTERS-1:0]    act_mask;

  logic [MAX_CLUSTERS:0]      tok_vld;
  logic [IDX_W-1:0]           tok_idx  [MAX_CLUSTERS+1];
  logic [nca_pkg::DIST_W-1:0] tok_dist [MAX_CLUSTERS+1];

  logic [IDX_W-1:0]           res_idx_r;
  logic [nca_pkg::DIST_W-1:0] res_dist_r;
  logic [nca_pkg::CIDX_W-1:0] out_idx_r;
  logic [nca_pkg::DIST_W-1:0] out_dist_r;
  logic                       out_vld_r;

  // Unpack the input word
  assign in_cidx  = in_tdata[2:0];
  assign in_fidx  = in_tdata[6:3];
  assign in_value = in_tdata[22:7];
  assign in_fire  = in_tvalid && in_tready;
  assign is_point = (in_tuser == nca_pkg::ACT_POINT);
  assign cidx_ok  = (32'(in_cidx) < MAX_CLUSTERS);
  assign fidx_ok  = (32'(in_fidx) < MAX_DIMENSIONS);
  assign addr     = DIW'(in_fidx);
  assign last_point = in_fire && is_point && in_tlast;

  // Broadcast control
  assign ctrl.wr_en  = in_fire && !is_point && cidx_ok && fidx_ok;
  assign ctrl.rd_en  = in_fire && is_point && fidx_ok;
  assign ctrl.acc_en = b_vld_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= nca_pkg::ACT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[nca_pkg::CFG_AW-1:2] == nca_pkg::REG_ACTIVE_CLUSTERS) begin
      act_r <= cfg_pwdata[nca_pkg::ACT_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[nca_pkg::CFG_AW-1:2] == nca_pkg::REG_ACTIVE_CLUSTERS)
                    ? {{(nca_pkg::CFG_DW-nca_pkg::ACT_W){1'b0}}, act_r} : '0;

  // Cell zero always takes part; a count above the table saturates
  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_mask
    assign act_mask[g] = (g == 0) || (32'(act_r) > g);
  end

  // Feature pipeline alongside the cells
  always_ff @(posedge clk) begin
    if (in_fire) begin
      feat_a_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      a_last_r <= 1'b0;
      b_last_r <= 1'b0;
      c_last_r <= 1'b0;
    end else begin
      a_vld_r  <= ctrl.rd_en;
      b_vld_r  <= a_vld_r;
      a_last_r <= last_point;
      b_last_r <= a_last_r;
      c_last_r <= b_last_r;
    end
  end

  // Launch the compare token once the last feature is summed
  assign tok_vld[0]  = c_last_r;
  assign tok_idx[0]  = '0;
  assign tok_dist[0] = nca_pkg::DIST_MAX;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    nca_cell #(
      .CELL_IDX       (g),
      .MAX_DIMENSIONS (MAX_DIMENSIONS),
      .DIW            (DIW),
      .IDX_W          (IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .active       (act_mask[g]),
      .ld_cidx      (in_cidx),
      .addr         (addr),
      .wr_data      (in_value),
      .feat         (feat_a_r),
      .tok_in_vld   (tok_vld[g]),
      .tok_in_idx   (tok_idx[g]),
      .tok_in_dist  (tok_dist[g]),
      .tok_out_vld  (tok_vld[g+1]),
      .tok_out_idx  (tok_idx[g+1]),
      .tok_out_dist (tok_dist[g+1])
    );
  end

  // Controller: state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nca_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Controller: next state and outputs
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      nca_pkg::ST_RUN: begin
        in_tready = 1'b1;
        if (last_point) begin
          state_nxt = nca_pkg::ST_SWEEP;
        end
      end
      nca_pkg::ST_SWEEP: begin
        if (tok_vld[MAX_CLUSTERS]) begin
          state_nxt = nca_pkg::ST_HOLD;
        end
      end
      nca_pkg::ST_HOLD: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = nca_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = nca_pkg::ST_RUN;
      end
    endcase
  end

  // Catch the winner at the end of the chain
  always_ff @(posedge clk) begin
    if (tok_vld[MAX_CLUSTERS]) begin
      res_idx_r  <= tok_idx[MAX_CLUSTERS];
      res_dist_r <= tok_dist[MAX_CLUSTERS];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= nca_pkg::CIDX_W'(res_idx_r);
      out_dist_r <= res_dist_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_dist_r, out_idx_r};

`ifndef SYNTHESIS
  // A final feature stops intake until its result is out
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    last_point |=> !in_tready)
    else $error("input accepted during compare sweep");

  // At most one compare token travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one compare token in the chain");

  // The chain only finishes while a sweep is under way
  a_end_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld[MAX_CLUSTERS] |-> state_r == nca_pkg::ST_SWEEP)
    else $error("compare token left the chain outside a sweep");

  // A new result is only shown out of the hold state
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == nca_pkg::ST_HOLD)
    else $error("result presented without a finished sweep");
`endif

endmodule
`default_nettype wire
